/* hw/rtl/slrd_pkg.sv */
// ----------------------------------------------------------------------------
// slrd_pkg: shared types and helpers for the sequence loss/reorder detector
// Holds the flow entry layout, the command/status structs between controller
// and datapath, event codes and the sequence number extraction function.
// ----------------------------------------------------------------------------
package slrd_pkg;

  localparam int FLOWS  = 256;
  localparam int FLOW_W = $clog2(FLOWS);

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

  // configuration register indexes
  localparam logic [3:0] CFG_SEQ_SIZE   = 4'd0;
  localparam logic [3:0] CFG_BYTE_ORDER = 4'd1;
  localparam logic [3:0] CFG_TIMEOUT    = 4'd2;
  localparam logic [3:0] CFG_DEBUG      = 4'd3;

  // event kinds
  localparam logic [2:0] EV_DEBUG    = 3'd0;
  localparam logic [2:0] EV_QUEUE    = 3'd1;
  localparam logic [2:0] EV_RAISE    = 3'd2;
  localparam logic [2:0] EV_DISORDER = 3'd3;
  localparam logic [2:0] EV_LOSS     = 3'd4;

  // debug levels
  localparam logic [1:0] DBG_INFO = 2'd1;
  localparam logic [1:0] DBG_WARN = 2'd2;

  // multiplier steps
  localparam logic [1:0] MUL_LO    = 2'd0;
  localparam logic [1:0] MUL_HI_LO = 2'd1;
  localparam logic [1:0] MUL_LO_HI = 2'd2;

  typedef struct packed {
    logic [63:0] expected;
    logic [63:0] adjusted_number;
    logic [31:0] problem_count;
    logic [31:0] run_length;
    logic [63:0] last_seen_ns;
    logic [63:0] problem_start_ns;
    logic [63:0] gap_sum;
    logic [15:0] last_queue;
  } entry_t;

  typedef struct packed {
    logic       capture;   // take the input word and read the entry
    logic       stage_a;   // resync and gap computation
    logic       mul_en;    // run one multiplier step
    logic [1:0] mul_step;
    logic       finish;    // form the product and compare
    logic       wb;        // write the entry back, set closing event
    logic       emit;      // present one pending event
  } cmd_t;

  typedef struct packed {
    logic ev_any;
    logic ev_more;
  } sts_t;

  function automatic logic [63:0] extract_seq(input logic [63:0] raw,
                                              input logic [1:0]  size_code,
                                              input logic        msb_first);
    logic [63:0] v;
    logic [3:0]  nb;
    logic [7:0]  b;
    v  = '0;
    nb = 4'd1 << size_code;
    for (int i = 0; i < 8; i++) begin
      b = raw[63-8*i -: 8];
      if (4'(i) < nb) begin
        if (msb_first) v[8*(int'(nb)-1-i) +: 8] = b;
        else           v[8*i +: 8] = b;
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] width_mask(input logic [1:0] size_code);
    logic [63:0] m;
    case (size_code)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/sequence_loss_reorder_detector_top.sv */
// ----------------------------------------------------------------------------
// sequence_loss_reorder_detector_top: per-flow loss and reordering detector
// Tracks the expected sequence count of 256 flows and reports events.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the in_* word with start high while busy is low; the word is
//   taken at that edge. Config: cfg_valid with cfg_index/cfg_data, cfg_ready
//   is always high; write only while busy is low.
//   Output: each event word appears for one cycle with out_valid high,
//   out_last marks the final word of a packet. The receiver cannot stall.
//   Steps: a packet passes through read, update, three steps of the shared
//   32x32 multiplier for the triangular test, compare, write-back and emit,
//   where each pending event word is sent in turn.
//   Reset: clears configuration to defaults and all flow valid bits, so
//   every flow entry reads as unused; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sequence_loss_reorder_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_flow_index,
  input  logic [63:0] in_seq_bytes,
  input  logic [63:0] in_now_ns,
  input  logic [15:0] in_queue_id,
  input  logic        in_at_queue_point,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_event_kind,
  output logic [63:0] out_seen_number,
  output logic [63:0] out_expected_count,
  output logic [15:0] out_queue_out,
  output logic [1:0]  out_level_out,
  output logic        out_last
);

  slrd_pkg::cmd_t cmd;
  slrd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  slrd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  slrd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_flow_index      (in_flow_index),
    .in_seq_bytes       (in_seq_bytes),
    .in_now_ns          (in_now_ns),
    .in_queue_id        (in_queue_id),
    .in_at_queue_point  (in_at_queue_point),
    .out_valid          (out_valid),
    .out_event_kind     (out_event_kind),
    .out_seen_number    (out_seen_number),
    .out_expected_count (out_expected_count),
    .out_queue_out      (out_queue_out),
    .out_level_out      (out_level_out),
    .out_last           (out_last)
  );

endmodule

/* hw/rtl/slrd_ctrl.sv */
// ----------------------------------------------------------------------------
// slrd_ctrl: sequencing controller
// Steps one packet through entry read, update, product, write-back and event
// emission, and tells the datapath what to do each cycle.
// ----------------------------------------------------------------------------
module slrd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  slrd_pkg::sts_t sts,
  output slrd_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_A    = 3'd1;
  localparam logic [2:0] ST_M0   = 3'd2;
  localparam logic [2:0] ST_M1   = 3'd3;
  localparam logic [2:0] ST_M2   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_WB   = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_A;
        end
      end
      ST_A: begin
        cmd.stage_a = 1'b1;
        state_nxt   = ST_M0;
      end
      ST_M0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = slrd_pkg::MUL_LO;
        state_nxt    = ST_M1;
      end
      ST_M1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = slrd_pkg::MUL_HI_LO;
        state_nxt    = ST_M2;
      end
      ST_M2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = slrd_pkg::MUL_LO_HI;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // drop out once the final word has gone
        if (sts.ev_any) cmd.emit = 1'b1;
        if (!sts.ev_more) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/slrd_dp.sv */
// ----------------------------------------------------------------------------
// slrd_dp: datapath
// Flow table memory with valid bits, configuration registers, entry update
// logic, a shared 32x32 multiplier for the triangular test, event flags.
// ----------------------------------------------------------------------------
module slrd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slrd_pkg::cmd_t               cmd,
  output slrd_pkg::sts_t               sts,
  input  logic                         cfg_valid,
  input  logic [3:0]                   cfg_index,
  input  logic [11:0]                  cfg_data,
  input  logic [slrd_pkg::FLOW_W-1:0]  in_flow_index,
  input  logic [63:0]                  in_seq_bytes,
  input  logic [63:0]                  in_now_ns,
  input  logic [15:0]                  in_queue_id,
  input  logic                         in_at_queue_point,
  output logic                         out_valid,
  output logic [2:0]                   out_event_kind,
  output logic [63:0]                  out_seen_number,
  output logic [63:0]                  out_expected_count,
  output logic [15:0]                  out_queue_out,
  output logic [1:0]                   out_level_out,
  output logic                         out_last
);

  // configuration
  logic [1:0]  seq_size_r;
  logic        msb_first_r;
  logic [11:0] timeout_r;
  logic [1:0]  debug_r;
  logic [63:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_size_r  <= 2'd1;
      msb_first_r <= 1'b1;
      timeout_r   <= '0;
      debug_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        slrd_pkg::CFG_SEQ_SIZE:   seq_size_r  <= cfg_data[1:0];
        slrd_pkg::CFG_BYTE_ORDER: msb_first_r <= cfg_data[0];
        slrd_pkg::CFG_TIMEOUT:    timeout_r   <= cfg_data;
        slrd_pkg::CFG_DEBUG:      debug_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= 64'(timeout_r) * slrd_pkg::NS_PER_SEC;
  end

  // flow table
  slrd_pkg::entry_t mem [slrd_pkg::FLOWS];
  slrd_pkg::entry_t rd_r;
  logic [slrd_pkg::FLOWS-1:0] valid_r;
  logic [slrd_pkg::FLOW_W-1:0] idx_r;
  logic [63:0] raw_r, now_r;
  logic [15:0] qid_r;
  logic        qpt_r;
  slrd_pkg::entry_t wb_entry;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r  <= mem[in_flow_index];
      idx_r <= in_flow_index;
      raw_r <= in_seq_bytes;
      now_r <= in_now_ns;
      qid_r <= in_queue_id;
      qpt_r <= in_at_queue_point;
    end
    if (cmd.wb) mem[idx_r] <= wb_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (cmd.wb) valid_r[idx_r] <= 1'b1;
  end

  // stage A
  slrd_pkg::entry_t cur;
  logic [63:0] seq, e1, adj_a, gap, gs0, gs1, ps1;
  logic [31:0] pc0, pc1, rl0;
  logic [15:0] lq1;
  logic        resync, qev, prob;
  logic [63:0] wmask;

  always_comb begin
    cur    = valid_r[idx_r] ? rd_r : '0;
    wmask  = slrd_pkg::width_mask(seq_size_r);
    seq    = slrd_pkg::extract_seq(raw_r, seq_size_r, msb_first_r);
    resync = (seq != cur.expected) &&
             ((cur.last_seen_ns == '0) ||
              ((timeout_r != '0) && ((now_r - cur.last_seen_ns) >= limit_r)));
    e1     = resync ? seq : cur.expected;
    pc0    = resync ? '0 : cur.problem_count;
    rl0    = resync ? '0 : cur.run_length;
    pc1    = pc0 + 32'(seq != e1);
    qev    = qpt_r && (debug_r == slrd_pkg::DBG_WARN) && (qid_r != cur.last_queue);
    lq1    = qev ? qid_r : cur.last_queue;
    prob   = (pc1 != '0);
    gs0    = (prob && rl0 == '0) ? '0 : cur.gap_sum;
    ps1    = (prob && rl0 == '0) ? now_r : cur.problem_start_ns;
    // lift a wrapped number above the expected count
    adj_a  = seq;
    if (seq < e1 && seq_size_r != 2'd3) adj_a = seq + (wmask + 64'd1);
    gap    = adj_a - e1 + 64'd1;
    gs1    = (prob && gap != '0 && !gap[63]) ? gs0 + gap : gs0;
  end

  logic [63:0] seq_r, e1_r, adj_r, gap_r, gs_r, ps_r;
  logic [31:0] pc_r, rl_r;
  logic [15:0] lq_r;
  logic        prob_r;
  logic        ev_dbg_r, ev_q_r, ev_rw_r, ev_end_r;
  logic        rw_raise_r, end_loss_r;

  always_ff @(posedge clk) begin
    if (cmd.stage_a) begin
      seq_r  <= seq;
      e1_r   <= e1;
      adj_r  <= prob ? adj_a : seq;
      gap_r  <= gap;
      gs_r   <= gs1;
      ps_r   <= ps1;
      pc_r   <= pc1;
      rl_r   <= rl0;
      lq_r   <= lq1;
      prob_r <= prob;
    end
  end

  // shared multiplier: low 64 bits of (gap + 1) * gap
  logic [63:0] mul_a, prod_lo_r, prod;
  logic [31:0] op_x, op_y, cross_r;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = gap_r + 64'd1;
    case (cmd.mul_step)
      slrd_pkg::MUL_LO:    begin op_x = mul_a[31:0];  op_y = gap_r[31:0];  end
      slrd_pkg::MUL_HI_LO: begin op_x = mul_a[63:32]; op_y = gap_r[31:0];  end
      slrd_pkg::MUL_LO_HI: begin op_x = mul_a[31:0];  op_y = gap_r[63:32]; end
      default:             begin op_x = '0;           op_y = '0;           end
    endcase
    mul_p = 64'(op_x) * 64'(op_y);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        slrd_pkg::MUL_LO:    prod_lo_r <= mul_p;
        slrd_pkg::MUL_HI_LO: cross_r   <= mul_p[31:0];
        slrd_pkg::MUL_LO_HI: cross_r   <= cross_r + mul_p[31:0];
        default: ;
      endcase
    end
  end

  logic match_r, lost_r;
  logic [63:0] half;

  always_comb begin
    prod = prod_lo_r + {cross_r, 32'd0};
    half = {prod[63], prod[63:1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      match_r <= (half == gs_r);
      lost_r  <= (seq_r == ((e1_r - 64'd1) & wmask)) ||
                 ((timeout_r != '0) && ((now_r - ps_r) >= limit_r));
    end
  end

  // write-back entry
  always_comb begin
    wb_entry.adjusted_number  = adj_r;
    wb_entry.problem_count    = pc_r;
    wb_entry.run_length       = rl_r;
    wb_entry.last_seen_ns     = now_r;
    wb_entry.problem_start_ns = ps_r;
    wb_entry.gap_sum          = gs_r;
    wb_entry.last_queue       = lq_r;
    wb_entry.expected         = (e1_r + 64'd1) & wmask;
    if (prob_r) begin
      if (match_r) begin
        wb_entry.expected      = (adj_r + 64'd1) & wmask;
        wb_entry.problem_count = '0;
        wb_entry.run_length    = '0;
      end else if (lost_r) begin
        wb_entry = '0;
      end else begin
        wb_entry.expected   = e1_r;
        wb_entry.run_length = rl_r + 32'd1;
      end
    end
  end

  // event flags, sent in order: info, queue change, raise or warn, close
  logic sel_dbg, sel_q, sel_rw, sel_end;
  logic [3:0] left;

  always_comb begin
    sel_dbg = ev_dbg_r;
    sel_q   = !ev_dbg_r && ev_q_r;
    sel_rw  = !ev_dbg_r && !ev_q_r && ev_rw_r;
    sel_end = !ev_dbg_r && !ev_q_r && !ev_rw_r && ev_end_r;
    left    = {ev_dbg_r && !sel_dbg, ev_q_r && !sel_q,
               ev_rw_r && !sel_rw, ev_end_r && !sel_end};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_dbg_r <= 1'b0;
      ev_q_r   <= 1'b0;
      ev_rw_r  <= 1'b0;
      ev_end_r <= 1'b0;
    end else if (cmd.stage_a) begin
      ev_dbg_r   <= (debug_r == slrd_pkg::DBG_INFO);
      ev_q_r     <= qev;
      ev_rw_r    <= prob && ((rl0 == '0) || (debug_r == slrd_pkg::DBG_WARN));
      rw_raise_r <= (rl0 == '0);
    end else if (cmd.wb) begin
      ev_end_r   <= prob_r && (match_r || lost_r);
      end_loss_r <= !match_r;
    end else if (cmd.emit) begin
      ev_dbg_r <= left[3];
      ev_q_r   <= left[2];
      ev_rw_r  <= left[1];
      ev_end_r <= left[0];
    end
  end

  assign sts.ev_any  = ev_dbg_r | ev_q_r | ev_rw_r | ev_end_r;
  assign sts.ev_more = (left != '0);

  always_comb begin
    out_valid          = cmd.emit;
    out_seen_number    = seq_r;
    out_expected_count = e1_r;
    out_queue_out      = sel_q ? lq_r : '0;
    out_level_out      = '0;
    out_event_kind     = slrd_pkg::EV_DEBUG;
    out_last           = (left == '0);
    if (sel_dbg) out_level_out = slrd_pkg::DBG_INFO;
    if (sel_q)   out_event_kind = slrd_pkg::EV_QUEUE;
    if (sel_rw) begin
      if (rw_raise_r) out_event_kind = slrd_pkg::EV_RAISE;
      else            out_level_out  = slrd_pkg::DBG_WARN;
    end
    if (sel_end) out_event_kind = end_loss_r ? slrd_pkg::EV_LOSS : slrd_pkg::EV_DISORDER;
  end

endmodule

/* hw/rtl/slrd_checker.sv */
// ----------------------------------------------------------------------------
// slrd_checker: port-level checks for the detector
// Watches the top level's ports and flags protocol and event-order slips.
// ----------------------------------------------------------------------------
module slrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_event_kind,
  input logic [1:0] out_level_out,
  input logic       out_last
);

  // words only leave while a packet is in progress
  a_out_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("event word outside a packet");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted packet did not start");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid) else $error("word after last");

  a_level_debug: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != slrd_pkg::EV_DEBUG) |-> (out_level_out == 2'd0))
    else $error("level set on a non-debug event");

endmodule

bind sequence_loss_reorder_detector_top slrd_checker u_slrd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_event_kind (out_event_kind),
  .out_level_out  (out_level_out),
  .out_last       (out_last)
);
